/* design/cmdsplit_pkg.sv */
// Shared constants and types for the command line argument splitter.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package cmdsplit_pkg;

    localparam int MAX_SLASH_RUN_DEF = 32;

    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_QUOTE  = 16'h0022;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_TERM = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    typedef struct packed {
        logic load;
        logic emit_slash;
        logic emit_tail;
        logic emit_done;
    } cmd_t;

    typedef struct packed {
        logic plan_slash_nz;
        logic plan_tail;
        logic plan_done;
        logic slash_one;
        logic tail_valid;
        logic done_valid;
        logic out_free;
    } status_t;

endpackage

/* design/cmdsplit_ctrl.sv */
// Controller for the splitter: sequences backslash, tail and line-done results.
// Depends on cmdsplit_pkg for the command and status structs.
`timescale 1ns / 1ps

module cmdsplit_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  cmdsplit_pkg::status_t sts,
    output cmdsplit_pkg::cmd_t    cmd,
    output logic                  in_stall
);
    import cmdsplit_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SLASH,
        S_TAIL,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.plan_slash_nz)
                        state_next = S_SLASH;
                    else if (sts.plan_tail)
                        state_next = S_TAIL;
                    else if (sts.plan_done)
                        state_next = S_DONE;
                    else
                        state_next = S_IDLE;
                end
            end
            S_SLASH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_slash = 1'b1;
                    if (sts.slash_one)
                    begin
                        if (sts.tail_valid)
                            state_next = S_TAIL;
                        else if (sts.done_valid)
                            state_next = S_DONE;
                        else
                            state_next = S_IDLE;
                    end
                end
            end
            S_TAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_tail = 1'b1;
                    state_next    = sts.done_valid ? S_DONE : S_IDLE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* design/cmdsplit_dp.sv */
// Datapath for the splitter: parser state, per-transaction result plan, output register.
// Depends on cmdsplit_pkg for character codes, result kinds and the control structs.
`timescale 1ns / 1ps

module cmdsplit_dp #(
    parameter int MAX_SLASH_RUN = cmdsplit_pkg::MAX_SLASH_RUN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [15:0]           char_code,
    input  logic                  end_of_line,
    input  logic                  out_stall,
    input  cmdsplit_pkg::cmd_t    cmd,
    output cmdsplit_pkg::status_t sts,
    output logic                  out_valid,
    output logic [1:0]            kind,
    output logic [15:0]           out_char,
    output logic [15:0]           arg_count,
    output logic                  overflow,
    output logic                  last
);
    import cmdsplit_pkg::*;

    localparam int SLASH_W = $clog2(MAX_SLASH_RUN + 1);
    localparam logic [SLASH_W-1:0] SLASH_MAX = SLASH_W'(MAX_SLASH_RUN);

    // parser state
    logic               in_quotes_reg,   in_quotes_next;
    logic               in_arg_reg,      in_arg_next;
    logic               quote_pend_reg,  quote_pend_next;
    logic [SLASH_W-1:0] slashes_reg,     slashes_next;
    logic [15:0]        counter_reg,     counter_next;
    logic               ovf_seen_reg,    ovf_seen_next;

    // plan for the current transaction
    logic [SLASH_W-1:0] plan_slash;
    logic               plan_tail;
    logic [1:0]         plan_kind;
    logic [15:0]        plan_char;
    logic               plan_done;
    logic [15:0]        plan_cnt;
    logic               plan_ovf;

    logic [SLASH_W-1:0] slash_left_reg, slash_left_next;
    logic               tail_valid_reg, tail_valid_next;
    logic [1:0]         tail_kind_reg;
    logic [15:0]        tail_char_reg;
    logic               done_valid_reg, done_valid_next;
    logic [15:0]        cap_cnt_reg;
    logic               cap_ovf_reg;

    logic               out_valid_reg;
    logic [1:0]         kind_reg;
    logic [15:0]        out_char_reg;
    logic [15:0]        arg_count_reg;
    logic               overflow_reg;
    logic               last_reg;

    logic out_free;
    logic is_blank;
    logic handled;

    assign is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        in_quotes_next  = in_quotes_reg;
        in_arg_next     = in_arg_reg;
        quote_pend_next = quote_pend_reg;
        slashes_next    = slashes_reg;
        counter_next    = counter_reg;
        ovf_seen_next   = ovf_seen_reg;
        plan_slash      = '0;
        plan_tail       = 1'b0;
        plan_kind       = KIND_CHAR;
        plan_char       = 16'd0;
        plan_done       = 1'b0;
        handled         = 1'b0;
        plan_cnt        = counter_reg;
        plan_ovf        = ovf_seen_reg;

        if (end_of_line || (char_code == 16'd0))
        begin
            plan_slash      = slashes_reg;
            plan_tail       = in_arg_reg;
            plan_kind       = KIND_TERM;
            plan_done       = 1'b1;
            in_quotes_next  = 1'b0;
            in_arg_next     = 1'b0;
            quote_pend_next = 1'b0;
            slashes_next    = '0;
            counter_next    = 16'd0;
            ovf_seen_next   = 1'b0;
        end
        else
        begin
            if (quote_pend_reg)
            begin
                quote_pend_next = 1'b0;
                if (char_code == CH_QUOTE)
                begin
                    plan_tail = 1'b1;
                    plan_char = CH_QUOTE;
                    handled   = 1'b1;
                end
                else
                begin
                    in_quotes_next = 1'b0;
                end
            end
            if (!handled && !in_arg_reg)
            begin
                if (is_blank)
                    handled = 1'b1;
                else
                begin
                    in_arg_next    = 1'b1;
                    in_quotes_next = 1'b0;
                    if (counter_reg != 16'hFFFF)
                        counter_next = counter_reg + 16'd1;
                end
            end
            if (!handled)
            begin
                if (char_code == CH_BSLASH)
                begin
                    if (slashes_reg < SLASH_MAX)
                        slashes_next = slashes_reg + SLASH_W'(1);
                    else
                        ovf_seen_next = 1'b1;
                end
                else if ((slashes_reg != '0) && (char_code == CH_QUOTE))
                begin
                    slashes_next = '0;
                    plan_slash   = slashes_reg >> 1;
                    if (slashes_reg[0])
                    begin
                        plan_tail = 1'b1;
                        plan_char = CH_QUOTE;
                    end
                    else
                        in_quotes_next = !in_quotes_next;
                end
                else
                begin
                    slashes_next = '0;
                    plan_slash   = slashes_reg;
                    if (char_code == CH_QUOTE)
                    begin
                        if (in_quotes_next)
                            quote_pend_next = 1'b1;
                        else
                            in_quotes_next = 1'b1;
                    end
                    else if (is_blank && !in_quotes_next)
                    begin
                        plan_tail      = 1'b1;
                        plan_kind      = KIND_TERM;
                        in_arg_next    = 1'b0;
                        in_quotes_next = 1'b0;
                    end
                    else
                    begin
                        plan_tail = 1'b1;
                        plan_char = char_code;
                    end
                end
            end
            plan_cnt = counter_next;
            plan_ovf = ovf_seen_next;
        end
    end

    always_comb
    begin
        slash_left_next = slash_left_reg;
        tail_valid_next = tail_valid_reg;
        done_valid_next = done_valid_reg;
        if (cmd.load)
        begin
            slash_left_next = plan_slash;
            tail_valid_next = plan_tail;
            done_valid_next = plan_done;
        end
        else if (cmd.emit_slash)
            slash_left_next = slash_left_reg - SLASH_W'(1);
        else if (cmd.emit_tail)
            tail_valid_next = 1'b0;
        else if (cmd.emit_done)
            done_valid_next = 1'b0;
    end

    assign sts.plan_slash_nz = (plan_slash != '0);
    assign sts.plan_tail     = plan_tail;
    assign sts.plan_done     = plan_done;
    assign sts.slash_one     = (slash_left_reg == SLASH_W'(1));
    assign sts.tail_valid    = tail_valid_reg;
    assign sts.done_valid    = done_valid_reg;
    assign sts.out_free      = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg  <= 1'b0;
            in_arg_reg     <= 1'b0;
            quote_pend_reg <= 1'b0;
            slashes_reg    <= '0;
            counter_reg    <= 16'd0;
            ovf_seen_reg   <= 1'b0;
            slash_left_reg <= '0;
            tail_valid_reg <= 1'b0;
            done_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                in_quotes_reg  <= in_quotes_next;
                in_arg_reg     <= in_arg_next;
                quote_pend_reg <= quote_pend_next;
                slashes_reg    <= slashes_next;
                counter_reg    <= counter_next;
                ovf_seen_reg   <= ovf_seen_next;
            end
            slash_left_reg <= slash_left_next;
            tail_valid_reg <= tail_valid_next;
            done_valid_reg <= done_valid_next;
            if (out_free)
                out_valid_reg <= cmd.emit_slash || cmd.emit_tail || cmd.emit_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tail_kind_reg <= plan_kind;
            tail_char_reg <= plan_char;
            cap_cnt_reg   <= plan_cnt;
            cap_ovf_reg   <= plan_ovf;
        end
        if (out_free)
        begin
            arg_count_reg <= cap_cnt_reg;
            overflow_reg  <= cap_ovf_reg;
            if (cmd.emit_slash)
            begin
                kind_reg     <= KIND_CHAR;
                out_char_reg <= CH_BSLASH;
                last_reg     <= sts.slash_one && !tail_valid_reg && !done_valid_reg;
            end
            else if (cmd.emit_tail)
            begin
                kind_reg     <= tail_kind_reg;
                out_char_reg <= tail_char_reg;
                last_reg     <= !done_valid_reg;
            end
            else
            begin
                kind_reg     <= KIND_DONE;
                out_char_reg <= 16'd0;
                last_reg     <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_char  = out_char_reg;
    assign arg_count = arg_count_reg;
    assign overflow  = overflow_reg;
    assign last      = last_reg;

endmodule

/* design/command_line_argument_splitter.sv */
// Command line argument splitter, top level.
// Input channel: in_valid/in_stall carry one UTF-16 code unit (char_code) or an
// end_of_line mark per transaction; a zero code also ends the line.
// Output channel: out_valid/out_stall carry one result per transaction: kind
// (character, terminator, line done), out_char, arg_count, overflow, and last
// on the final result caused by an input transaction.
// Each input transaction is taken in, then its results are sent in turn: held
// backslashes one per cycle while the output is free, then at most one tail
// result, then line done on end of line. A transaction with no result leaves
// in_stall low; one with results holds in_stall until its last result leaves
// the plan. The sequencing controller is the limit: one result leaves the
// plan per cycle while the output register is free. Results pass from the
// plan registers to the output register, which takes a new result in the same
// cycle the previous one is taken; when out_stall is high the results hold
// and in_stall stays high until the plan drains.
// Reset clears the parser state, the plan and the output valid at once.
// Depends on cmdsplit_pkg, cmdsplit_ctrl and cmdsplit_dp.
`timescale 1ns / 1ps

module command_line_argument_splitter #(
    parameter int MAX_SLASH_RUN = cmdsplit_pkg::MAX_SLASH_RUN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] char_code,
    input  logic        end_of_line,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] out_char,
    output logic [15:0] arg_count,
    output logic        overflow,
    output logic        last
);
    import cmdsplit_pkg::*;

    cmd_t    cmd;
    status_t sts;

    cmdsplit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    cmdsplit_dp #(
        .MAX_SLASH_RUN (MAX_SLASH_RUN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (char_code),
        .end_of_line (end_of_line),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .kind        (kind),
        .out_char    (out_char),
        .arg_count   (arg_count),
        .overflow    (overflow),
        .last        (last)
    );

`ifndef ASSERT_OFF
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_DONE) |-> last)
        else $error("line done result without last");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_CHAR) |-> (out_char == 16'd0))
        else $error("non-character result carries a character");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_char)
            && $stable(arg_count) && $stable(overflow) && $stable(last))
        else $error("stalled result changed");
`endif

endmodule

/* verif/tb_command_line_argument_splitter.sv */
// Testbench for command_line_argument_splitter: directed and random command lines,
// checked against a built-in predictor of the splitting rules.
// Depends on cmdsplit_pkg and the design under design/.
`timescale 1ns / 1ps

module tb_command_line_argument_splitter;
    import cmdsplit_pkg::*;

    localparam int  SLASH_LIMIT  = MAX_SLASH_RUN_DEF;
    localparam real CLK_PERIOD   = 20.0;
    localparam int  CYCLE_LIMIT  = 4_000_000;
    localparam int  DRAIN_CYCLES = 60;
    localparam int  PHASE_ITEMS  = 50;

    typedef enum int
    {
        MODE_STEADY,
        MODE_SENDER_GAPS,
        MODE_RECEIVER_STALLS,
        MODE_BOTH
    } idle_mode_e;

    typedef struct
    {
        logic [15:0] code;
        logic        eol;
        idle_mode_e  mode;
    } char_item_t;

    typedef struct
    {
        logic [1:0]  kind;
        logic [15:0] ch;
        logic [15:0] count;
        logic        ovf;
        logic        last;
    } split_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] char_code = 16'h0000;
    logic        end_of_line = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [15:0] out_char;
    logic [15:0] arg_count;
    logic        overflow;
    logic        last;

    char_item_t    line_chars[$];
    split_result_t args_due[$];
    idle_mode_e    recv_mode = MODE_STEADY;
    logic          in_taken = 1'b0;
    int            fail_count = 0;
    int            cycle_count = 0;

    // predictor state
    logic        quoting;
    logic        in_arg;
    logic        quote_held;
    int          slash_run;
    logic [15:0] arg_total;
    logic        slash_overflow;

    command_line_argument_splitter #(
        .MAX_SLASH_RUN(SLASH_LIMIT)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .end_of_line(end_of_line),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_char   (out_char),
        .arg_count  (arg_count),
        .overflow   (overflow),
        .last       (last)
    );

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    function automatic void clear_split_state();
        quoting        = 1'b0;
        in_arg         = 1'b0;
        quote_held     = 1'b0;
        slash_run      = 0;
        arg_total      = 16'h0000;
        slash_overflow = 1'b0;
    endfunction

    function automatic void add_expected(logic [1:0] k, logic [15:0] ch);
        split_result_t r;
        r.kind  = k;
        r.ch    = ch;
        r.count = arg_total;
        r.ovf   = slash_overflow;
        r.last  = 1'b0;
        args_due.push_back(r);
    endfunction

    function automatic void split_code_unit(logic [15:0] c, logic eol);
        int   base;
        int   held;
        logic skip;
        logic blank;
        base  = args_due.size();
        skip  = 1'b0;
        blank = (c == CH_SPACE) || (c == CH_TAB);
        if (eol || c == 16'h0000)
        begin
            for (int i = 0; i < slash_run; i++)
                add_expected(KIND_CHAR, CH_BSLASH);
            if (in_arg)
                add_expected(KIND_TERM, 16'h0000);
            add_expected(KIND_DONE, 16'h0000);
            clear_split_state();
        end
        else
        begin
            if (quote_held)
            begin
                quote_held = 1'b0;
                if (c == CH_QUOTE)
                begin
                    add_expected(KIND_CHAR, CH_QUOTE);
                    skip = 1'b1;
                end
                else
                    quoting = 1'b0;
            end
            if (!skip && !in_arg)
            begin
                if (blank)
                    skip = 1'b1;
                else
                begin
                    in_arg  = 1'b1;
                    quoting = 1'b0;
                    if (arg_total != 16'hFFFF)
                        arg_total = arg_total + 16'd1;
                end
            end
            if (!skip && c == CH_BSLASH)
            begin
                if (slash_run < SLASH_LIMIT)
                    slash_run++;
                else
                    slash_overflow = 1'b1;
                skip = 1'b1;
            end
            if (!skip)
            begin
                held      = slash_run;
                slash_run = 0;
                if (held != 0 && c == CH_QUOTE)
                begin
                    for (int i = 0; i < held / 2; i++)
                        add_expected(KIND_CHAR, CH_BSLASH);
                    if (held % 2 == 1)
                        add_expected(KIND_CHAR, CH_QUOTE);
                    else
                        quoting = !quoting;
                end
                else
                begin
                    for (int i = 0; i < held; i++)
                        add_expected(KIND_CHAR, CH_BSLASH);
                    if (c == CH_QUOTE)
                    begin
                        if (quoting)
                            quote_held = 1'b1;
                        else
                            quoting = 1'b1;
                    end
                    else if (blank && !quoting)
                    begin
                        add_expected(KIND_TERM, 16'h0000);
                        in_arg  = 1'b0;
                        quoting = 1'b0;
                    end
                    else
                        add_expected(KIND_CHAR, c);
                end
            end
        end
        if (args_due.size() > base)
            args_due[args_due.size() - 1].last = 1'b1;
    endfunction

    function automatic int check_result(split_result_t exp_r, split_result_t act_r);
        int errs;
        errs = 0;
        if (act_r.kind !== exp_r.kind)
        begin
            $error("kind: expected %0d, got %0d", exp_r.kind, act_r.kind);
            errs++;
        end
        if (act_r.ch !== exp_r.ch)
        begin
            $error("out_char: expected %h, got %h", exp_r.ch, act_r.ch);
            errs++;
        end
        if (act_r.count !== exp_r.count)
        begin
            $error("arg_count: expected %0d, got %0d", exp_r.count, act_r.count);
            errs++;
        end
        if (act_r.ovf !== exp_r.ovf)
        begin
            $error("overflow: expected %0d, got %0d", exp_r.ovf, act_r.ovf);
            errs++;
        end
        if (act_r.last !== exp_r.last)
        begin
            $error("last: expected %0d, got %0d", exp_r.last, act_r.last);
            errs++;
        end
        return errs;
    endfunction

    // monitor and predictor
    always @(posedge clk)
    begin
        split_result_t seen;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen.kind  = kind;
                seen.ch    = out_char;
                seen.count = arg_count;
                seen.ovf   = overflow;
                seen.last  = last;
                if (args_due.size() == 0)
                begin
                    $error("result transaction with nothing expected: kind %0d", kind);
                    fail_count++;
                end
                else
                    fail_count += check_result(args_due.pop_front(), seen);
            end
            if (in_valid && !in_stall)
                split_code_unit(char_code, end_of_line);
        end
        in_taken <= rst_n && in_valid && !in_stall;
    end

    // driver
    always @(negedge clk)
    begin
        char_item_t nxt;
        logic       gap;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                gap = 1'b0;
                if (line_chars.size() > 0)
                begin
                    if (line_chars[0].mode == MODE_SENDER_GAPS)
                        gap = ($urandom_range(99) < 75);
                    else if (line_chars[0].mode == MODE_BOTH)
                        gap = ($urandom_range(99) < 38);
                end
                if (line_chars.size() > 0 && !gap)
                begin
                    nxt = line_chars.pop_front();
                    in_valid    <= 1'b1;
                    char_code   <= nxt.code;
                    end_of_line <= nxt.eol;
                    recv_mode   <= nxt.mode;
                end
                else
                    in_valid <= 1'b0;
            end
            if (recv_mode == MODE_RECEIVER_STALLS)
                out_stall <= ($urandom_range(99) < 75);
            else if (recv_mode == MODE_BOTH)
                out_stall <= ($urandom_range(99) < 38);
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_command_line_argument_splitter failed");
            $finish;
        end
    end

    function automatic void push_code(logic [15:0] c, idle_mode_e mode);
        char_item_t it;
        it.code = c;
        it.eol  = 1'b0;
        it.mode = mode;
        line_chars.push_back(it);
    endfunction

    function automatic void push_eol(logic [15:0] c, idle_mode_e mode);
        char_item_t it;
        it.code = c;
        it.eol  = 1'b1;
        it.mode = mode;
        line_chars.push_back(it);
    endfunction

    function automatic void push_text(string s, idle_mode_e mode);
        for (int i = 0; i < s.len(); i++)
            push_code({8'h00, s[i]}, mode);
    endfunction

    function automatic logic [15:0] pick_blank();
        return ($urandom_range(1) == 0) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic void push_random_line(idle_mode_e mode);
        int ntok;
        int len;
        ntok = $urandom_range(1, 5);
        if ($urandom_range(3) == 0)
            push_code(pick_blank(), mode);
        for (int t = 0; t < ntok; t++)
        begin
            case ($urandom_range(7))
                2:
                    push_code(16'($urandom_range(1, 16'hFFFF)), mode);
                3:
                begin
                    len = ($urandom_range(15) == 0) ? $urandom_range(SLASH_LIMIT - 2,
                        SLASH_LIMIT + 6) : $urandom_range(1, 5);
                    for (int j = 0; j < len; j++)
                        push_code(CH_BSLASH, mode);
                    case ($urandom_range(2))
                        0: push_code(CH_QUOTE, mode);
                        1: push_code(pick_blank(), mode);
                        default: push_code(16'($urandom_range(16'h21, 16'h7E)), mode);
                    endcase
                end
                4:
                begin
                    push_code(CH_QUOTE, mode);
                    len = $urandom_range(0, 4);
                    for (int j = 0; j < len; j++)
                    begin
                        case ($urandom_range(4))
                            0: push_code(pick_blank(), mode);
                            1: push_text("\"\"", mode);
                            2: push_code(CH_BSLASH, mode);
                            default: push_code(16'($urandom_range(16'h21, 16'h7E)), mode);
                        endcase
                    end
                    if ($urandom_range(4) != 0)
                        push_code(CH_QUOTE, mode);
                end
                5:
                    push_code(CH_QUOTE, mode);
                6:
                    push_code(pick_blank(), mode);
                default:
                begin
                    len = $urandom_range(1, 4);
                    for (int j = 0; j < len; j++)
                        push_code(16'($urandom_range(16'h21, 16'h7E)), mode);
                end
            endcase
            if ($urandom_range(4) != 0)
                push_code(pick_blank(), mode);
        end
        if ($urandom_range(3) == 0)
            push_code(16'h0000, mode);
        else
            push_eol(16'($urandom_range(0, 16'hFFFF)), mode);
    endfunction

    initial
    begin
        int start;
        clear_split_state();

        // extremes of char_code, tab separator, ignored code on end of line
        push_code(16'h0061, MODE_STEADY);
        push_code(16'hFFFF, MODE_STEADY);
        push_code(CH_TAB, MODE_STEADY);
        push_code(16'h0001, MODE_STEADY);
        push_eol(16'hFFFF, MODE_STEADY);
        // empty quotes, doubled quote inside quotes, quote held at a zero code
        push_text("\"\" \"x\"\"y\"", MODE_STEADY);
        push_code(16'h0000, MODE_STEADY);
        // a backslash pair and a single backslash before quotes, literal run, trailing backslash at end of line
        push_text("\\\\\"\\\"\\\\\\z\\", MODE_STEADY);
        push_eol(16'h0000, MODE_STEADY);
        // backslash run past its bound
        for (int i = 0; i < SLASH_LIMIT + 3; i++)
            push_code(CH_BSLASH, MODE_STEADY);
        push_code(CH_QUOTE, MODE_STEADY);
        push_eol(16'h0022, MODE_STEADY);

        for (int m = MODE_STEADY; m <= MODE_BOTH; m++)
        begin
            start = line_chars.size();
            while (line_chars.size() - start < PHASE_ITEMS)
                push_random_line(idle_mode_e'(m));
        end

        push_random_line(MODE_BOTH);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (line_chars.size() != 0 || in_valid)
            @(posedge clk);
        while (args_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && args_due.size() == 0)
            $display("tb_command_line_argument_splitter passed");
        else
            $display("tb_command_line_argument_splitter failed");
        $finish;
    end

endmodule
